// File: hdl/bit_pkg.sv
// ----------------------------------------------------------------------------
// Binary image thinning package
// Shared constants for the thinning block and its checker.
// ----------------------------------------------------------------------------
package bit_pkg;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int CFG_W          = 9;
    localparam int CNT_W          = 16;
    localparam int ADDR_W         = 4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMEN  = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;
endpackage

// File: hdl/binary_image_thinning.sv
// A load or read is registered when accepted; its result word is registered
// from S_ACC. The last load of a frame runs thinning first: each subpass
// visits every pixel with eight neighbor reads, a center read and a decision,
// then a clear sweep. The frame-end word is registered in S_OUT after the last
// sweep. in_stall is high until a result word is taken, and during thinning.
// Reset: rst_n clears control state; the image memory holds no reset value.
// ----------------------------------------------------------------------------
// Binary image thinning
// Loads a binary frame, thins it by two-subpass iteration, reads it back.
// ----------------------------------------------------------------------------
module binary_image_thinning #(
    parameter int MAX_WIDTH  = bit_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bit_pkg::DEF_MAX_HEIGHT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bit_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic                         pixel_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         kind,
    output logic                         pixel_out,
    output logic                         frame_last,
    output logic [bit_pkg::CNT_W-1:0]    iterations_run
);
    import bit_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_IDLE, S_ACC, S_NB, S_DEC, S_CLR, S_OUT
    } state_t;

    // Image in bit 0, delete mark in bit 1, stored in raster order.
    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic             limen_reg;
    logic [CNT_W-1:0] limit_reg;

    state_t           state_reg;
    logic [XW:0]      x_reg;
    logic [YW:0]      y_reg;
    logic [AW-1:0]    c_reg, lpos_reg, rpos_reg;
    logic [3:0]       k_reg;
    logic [7:0]       q_reg;
    logic             nb_keep_reg;
    logic             second_reg, any_reg;
    logic [16:0]      count_reg;
    logic             req_reg, pix_reg;
    logic             ovalid_reg, okind_reg, opix_reg, olast_reg;
    logic [CNT_W-1:0] oiter_reg;

    logic [XW:0] w_eff;
    logic [YW:0] h_eff;
    logic [AW:0] n_eff;
    logic        cfg_wr;

    always_comb
    begin
        if (width_reg == '0) w_eff = (XW+1)'(1);
        else if (int'(width_reg) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
        else w_eff = (XW+1)'(width_reg);
        if (height_reg == '0) h_eff = (YW+1)'(1);
        else if (int'(height_reg) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
        else h_eff = (YW+1)'(height_reg);
    end

    assign n_eff = (AW+1)'(w_eff) * (AW+1)'(h_eff);

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_LIMEN:  prdata = 32'(limen_reg);
            default:    prdata = 32'(limit_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
            limen_reg  <= 1'b0;
            limit_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_LIMEN:  limen_reg  <= pwdata[0];
                default:    limit_reg  <= pwdata[CNT_W-1:0];
            endcase
        end
    end

    // Neighbor offset for step k: P2,P3,P4,P5,P6,P7,P8,P9, then P1.
    logic signed [2:0] dy, dx;
    always_comb
    begin
        unique case (k_reg)
            4'd0: begin dy = -3'sd1; dx =  3'sd0; end
            4'd1: begin dy = -3'sd1; dx =  3'sd1; end
            4'd2: begin dy =  3'sd0; dx =  3'sd1; end
            4'd3: begin dy =  3'sd1; dx =  3'sd1; end
            4'd4: begin dy =  3'sd1; dx =  3'sd0; end
            4'd5: begin dy =  3'sd1; dx = -3'sd1; end
            4'd6: begin dy =  3'sd0; dx = -3'sd1; end
            4'd7: begin dy = -3'sd1; dx = -3'sd1; end
            default: begin dy = 3'sd0; dx = 3'sd0; end
        endcase
    end

    logic signed [XW+1:0] nx;
    logic signed [YW+1:0] ny;
    logic                 nb_in;
    assign nx = $signed({1'b0, x_reg}) + (XW+2)'(dx);
    assign ny = $signed({1'b0, y_reg}) + (YW+2)'(dy);
    assign nb_in = nx >= 0 && ny >= 0 && nx < $signed({1'b0, w_eff})
                   && ny < $signed({1'b0, h_eff});

    // Out-of-frame neighbors may land on any address; nb_keep_reg masks them.
    logic [AW-1:0] row_off, nb_addr;
    always_comb
    begin
        if (dy < 0)
            row_off = AW'(0) - AW'(w_eff);
        else if (dy > 0)
            row_off = AW'(w_eff);
        else
            row_off = '0;
        nb_addr = c_reg + row_off + AW'(dx);
    end

    // Decision for the gathered ring; the center pixel read lands in this cycle.
    logic [3:0] sum;
    logic [3:0] trans;
    logic       ok, del;
    always_comb
    begin
        sum   = '0;
        trans = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + 4'(q_reg[i]);
            if (!q_reg[i] && q_reg[(i+1)%8]) trans = trans + 4'd1;
        end
        if (!second_reg)
            ok = !(q_reg[0] && q_reg[2] && q_reg[4]) && !(q_reg[2] && q_reg[4] && q_reg[6]);
        else
            ok = !(q_reg[0] && q_reg[2] && q_reg[6]) && !(q_reg[0] && q_reg[4] && q_reg[6]);
        del = rd_data_reg[0] && sum >= 4'd2 && sum <= 4'd6 && trans == 4'd1 && ok;
    end

    logic x_end, y_end;
    assign x_end = x_reg == w_eff - (XW+1)'(1);
    assign y_end = y_reg == h_eff - (YW+1)'(1);

    // Load and read positions, wrapped when the frame has shrunk.
    logic [AW-1:0] lpos_u, rpos_u;
    logic          l_end, r_end;
    assign lpos_u = ({1'b0, lpos_reg} >= n_eff) ? '0 : lpos_reg;
    assign rpos_u = ({1'b0, rpos_reg} >= n_eff) ? '0 : rpos_reg;
    assign l_end  = {1'b0, lpos_u} == n_eff - (AW+1)'(1);
    assign r_end  = {1'b0, rpos_u} == n_eff - (AW+1)'(1);

    logic sweep_done;
    assign sweep_done = x_end && y_end;

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ovalid_reg;
    assign kind      = okind_reg;
    assign pixel_out = opix_reg;
    assign frame_last = olast_reg;
    assign iterations_run = oiter_reg;

    // Memory: one port, read data registered.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [1:0]    mem_wd;
    always_comb
    begin
        mem_we   = 1'b0;
        mem_wd   = '0;
        mem_addr = c_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && req_type == REQ_LOAD)
                begin
                    mem_we   = 1'b1;
                    mem_addr = lpos_u;
                    mem_wd   = {1'b0, pixel_in};
                end
                else
                    mem_addr = rpos_u;
            end
            S_NB:
                mem_addr = nb_addr;
            S_DEC:
            begin
                mem_we = 1'b1;
                mem_wd = {del, rd_data_reg[0]};
            end
            S_CLR:
            begin
                mem_we = k_reg == 4'd1;
                mem_wd = {1'b0, rd_data_reg[0] && !rd_data_reg[1]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_addr] <= mem_wd;
        rd_data_reg <= mem[mem_addr];
    end

    logic [16:0] cnt_next;
    assign cnt_next = count_reg + 17'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lpos_reg <= '0; rpos_reg <= '0; c_reg <= '0;
            x_reg <= '0; y_reg <= '0; k_reg <= '0;
            q_reg <= '0;
            second_reg <= 1'b0; any_reg <= 1'b0; count_reg <= '0;
            req_reg <= 1'b0; pix_reg <= 1'b0;
            ovalid_reg <= 1'b0; okind_reg <= 1'b0; opix_reg <= 1'b0;
            olast_reg <= 1'b0; oiter_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && !out_stall) ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= req_type;
                        state_reg <= S_ACC;
                        if (req_type == REQ_LOAD)
                        begin
                            pix_reg  <= l_end;
                            lpos_reg <= l_end ? '0 : lpos_u + AW'(1);
                        end
                        else
                        begin
                            pix_reg  <= r_end;
                            rpos_reg <= r_end ? '0 : rpos_u + AW'(1);
                        end
                    end
                end
                S_ACC:
                begin
                    // pix_reg holds the frame-end flag of this word.
                    if (req_reg == REQ_LOAD && pix_reg)
                    begin
                        rpos_reg <= '0;
                        if (limen_reg && limit_reg == '0)
                        begin
                            count_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            count_reg <= 17'd1;
                            second_reg <= 1'b0; any_reg <= 1'b0;
                            x_reg <= '0; y_reg <= '0; c_reg <= '0; k_reg <= '0;
                            state_reg <= S_NB;
                        end
                    end
                    else
                    begin
                        ovalid_reg <= 1'b1;
                        okind_reg  <= req_reg;
                        opix_reg   <= req_reg == REQ_READ ? rd_data_reg[0] : 1'b0;
                        olast_reg  <= pix_reg;
                        oiter_reg  <= '0;
                        state_reg  <= S_OUT;
                    end
                end
                S_NB:
                begin
                    // Read of step k issues now; its data lands at k+1.
                    if (k_reg != 4'd0)
                        q_reg[3'(k_reg - 4'd1)] <= rd_data_reg[0] && nb_keep_reg;
                    if (k_reg == 4'd8)
                        state_reg <= S_DEC;
                    else
                        k_reg <= k_reg + 4'd1;
                end
                S_DEC:
                begin
                    if (del) any_reg <= 1'b1;
                    k_reg <= '0;
                    if (sweep_done)
                    begin
                        x_reg <= '0; y_reg <= '0; c_reg <= '0;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        c_reg <= c_reg + AW'(1);
                        if (x_end) begin x_reg <= '0; y_reg <= y_reg + (YW+1)'(1); end
                        else x_reg <= x_reg + (XW+1)'(1);
                        state_reg <= S_NB;
                    end
                end
                S_CLR:
                begin
                    // Two-phase per pixel: k=0 issues the read, k=1 writes back.
                    if (k_reg == 4'd0)
                        k_reg <= 4'd1;
                    else
                    begin
                        k_reg <= '0;
                        if (sweep_done)
                        begin
                            x_reg <= '0; y_reg <= '0; c_reg <= '0;
                            if (!any_reg)
                                state_reg <= S_OUT;
                            else if (!second_reg)
                            begin
                                second_reg <= 1'b1; any_reg <= 1'b0;
                                state_reg <= S_NB;
                            end
                            else if (limen_reg && count_reg >= 17'(limit_reg))
                                state_reg <= S_OUT;
                            else
                            begin
                                count_reg <= cnt_next;
                                second_reg <= 1'b0; any_reg <= 1'b0;
                                state_reg <= S_NB;
                            end
                        end
                        else
                        begin
                            c_reg <= c_reg + AW'(1);
                            if (x_end)
                            begin x_reg <= '0; y_reg <= y_reg + (YW+1)'(1); end
                            else x_reg <= x_reg + (XW+1)'(1);
                        end
                    end
                end
                default:
                begin
                    if (req_reg == REQ_LOAD && pix_reg && !ovalid_reg)
                    begin
                        ovalid_reg <= 1'b1;
                        okind_reg  <= REQ_LOAD;
                        opix_reg   <= 1'b0;
                        olast_reg  <= 1'b1;
                        oiter_reg  <= count_reg > 17'd65535 ? CNT_W'(65535)
                                                           : count_reg[CNT_W-1:0];
                        pix_reg    <= 1'b0;
                    end
                    else if (!ovalid_reg || !out_stall)
                    begin
                        if (!(req_reg == REQ_LOAD && pix_reg))
                            state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // In-frame flag of the neighbor read issued in the previous cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nb_keep_reg <= 1'b0;
        else
            nb_keep_reg <= nb_in;
    end
endmodule

// File: hdl/bit_checker.sv
// ----------------------------------------------------------------------------
// Binary image thinning checker
// Port-level checks attached to the top level by bind.
// ----------------------------------------------------------------------------
module bit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       kind,
    input logic       pixel_out,
    input logic       frame_last,
    input logic [15:0] iterations_run
);
    import bit_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(frame_last))
        else $error("result word changed under stall");

    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == REQ_LOAD |-> pixel_out == 1'b0)
        else $error("load result carries a pixel");

    a_iter_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !(kind == REQ_LOAD && frame_last) |-> iterations_run == '0)
        else $error("iteration count outside frame end");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken back to back");
endmodule

bind binary_image_thinning bit_checker u_bit_checker (.*);
